### src/fcct_pkg.sv
// Package for the frame change capture trigger: request and result types,
// configuration register indexes, sequencer states and divider handshake types.
// No dependencies.
package fcct_pkg;

    // Channel lanes that exist in storage, and the width of one average.
    localparam int MAX_CH = 4;
    localparam int QUOT_W = 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_LIMIT       = 3'd4;

    // One pixel request.
    typedef struct packed {
        logic [7:0]  chan0;
        logic [7:0]  chan1;
        logic [7:0]  chan2;
        logic [7:0]  chan3;
        logic [63:0] now_time;
    } t_in_item;

    // One frame result.
    typedef struct packed {
        logic        capture;
        logic        colour_changed;
        logic [7:0]  avg0;
        logic [7:0]  avg1;
        logic [7:0]  avg2;
        logic [7:0]  avg3;
        logic [63:0] frame_time;
    } t_out_item;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV_START,
        S_DIV_WAIT,
        S_EMIT
    } t_state;

    // Divider control and status.
    typedef struct packed {
        logic start;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_rsp;

endpackage

### src/frame_change_capture_trigger.sv
// Top level of the frame change capture trigger: configuration registers,
// pixel accumulation, frame-end sequencer and output register.
// Depends on fcct_pkg and fcct_div.
//
//  Channel  | Signals                                  | Direction
//  ---------+------------------------------------------+----------
//  pixel    | i_in_valid, o_in_ready, i_in_data        | in
//  result   | o_out_valid, i_out_ready, o_out_data     | out
//  config   | i_cfg_we, i_cfg_index, i_cfg_data        | in
//
// A pixel that does not end a frame is accepted in S_IDLE, then S_CHECK
// compares the pixel count with the frame size. A frame's last pixel then
// runs each channel in turn through the shared divider (start, up to nine
// divider steps, result), and S_EMIT then loads the output register.
// Reset is synchronous and active low and needs no clearing pass. A result
// waiting at the output holds the sequencer only at its final load.
module frame_change_capture_trigger
    import fcct_pkg::*;
#(
    parameter int CHANNELS = 4,
    parameter int MAX_DIM  = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CNT_W = 2 * DIM_W;
    localparam int SUM_W = CNT_W + QUOT_W;
    localparam logic [1:0] CH_LAST = 2'(CHANNELS - 1);

    // Configuration registers.
    logic        r_rec_en;
    logic [12:0] r_width;
    logic [12:0] r_height;
    logic [7:0]  r_thresh;
    logic [31:0] r_tlimit;

    // Frame state.
    logic [SUM_W-1:0]  r_sum  [MAX_CH];
    logic [QUOT_W-1:0] r_prev [MAX_CH];
    logic [QUOT_W-1:0] r_avg  [MAX_CH];
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_total;
    logic              r_first;
    logic [63:0]       r_last_cap;
    logic [63:0]       r_now;
    logic              r_changed;
    logic [1:0]        r_ch;
    t_state            r_state;
    t_state            n_state;

    // Output register.
    logic      r_out_valid;
    t_out_item r_out;

    // Handshake and sequencer controls.
    logic       accept;
    logic       frame_end;
    logic       ch_done;
    logic       load_out;
    t_div_req   div_req;
    t_div_rsp   div_rsp;

    logic [7:0]       in_ch [MAX_CH];
    logic [DIM_W-1:0] w_dim;
    logic [DIM_W-1:0] h_dim;
    logic [CNT_W-1:0] total_next;
    logic [7:0]       diff;
    logic [63:0]      elapsed;
    logic             time_over;
    logic             capture;

    assign in_ch[0] = i_in_data.chan0;
    assign in_ch[1] = i_in_data.chan1;
    assign in_ch[2] = i_in_data.chan2;
    assign in_ch[3] = i_in_data.chan3;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec_en <= 1'b1;
            r_width  <= 13'd1280;
            r_height <= 13'd720;
            r_thresh <= 8'd16;
            r_tlimit <= 32'd1000000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RECORD_ENABLE:    r_rec_en <= i_cfg_data[0];
                CFG_FRAME_WIDTH:      r_width  <= i_cfg_data[12:0];
                CFG_FRAME_HEIGHT:     r_height <= i_cfg_data[12:0];
                CFG_CHANGE_THRESHOLD: r_thresh <= i_cfg_data[7:0];
                CFG_TIME_LIMIT:       r_tlimit <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Frame size: a zero dimension counts as one, a large one as the maximum.
    always_comb begin
        if (r_width == '0) begin
            w_dim = DIM_W'(1);
        end else if (32'(r_width) > 32'(MAX_DIM)) begin
            w_dim = DIM_W'(MAX_DIM);
        end else begin
            w_dim = DIM_W'(r_width);
        end
        if (r_height == '0) begin
            h_dim = DIM_W'(1);
        end else if (32'(r_height) > 32'(MAX_DIM)) begin
            h_dim = DIM_W'(MAX_DIM);
        end else begin
            h_dim = DIM_W'(r_height);
        end
    end

    assign total_next = CNT_W'(w_dim) * CNT_W'(h_dim);

    // The frame size product is registered every cycle.
    always_ff @(posedge i_clk) begin
        r_total <= total_next;
    end

    // Sequencer controls and next state.
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign frame_end  = (r_count >= r_total);
    assign ch_done    = div_rsp.done && (r_ch == CH_LAST);
    assign load_out   = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state       = r_state;
        div_req.start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept && r_rec_en) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = frame_end ? S_DIV_START : S_IDLE;
            end
            S_DIV_START: begin
                div_req.start = 1'b1;
                n_state       = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_rsp.done) begin
                    n_state = ch_done ? S_EMIT : S_DIV_START;
                end
            end
            S_EMIT: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Shared divider for the channel averages.
    fcct_div #(
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_dividend (r_sum[r_ch]),
        .i_divisor  (r_total),
        .o_rsp      (div_rsp)
    );

    // Distance of the new average from the previous frame's.
    assign diff = (div_rsp.quot > r_prev[r_ch]) ? (div_rsp.quot - r_prev[r_ch])
                                                : (r_prev[r_ch] - div_rsp.quot);

    // Elapsed time since the last capture, wrapping.
    assign elapsed   = r_now - r_last_cap;
    assign time_over = (elapsed > {32'd0, r_tlimit});
    assign capture   = r_changed || r_first || time_over;

    // Accumulation, per-channel results and frame bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < MAX_CH; c++) begin
                r_sum[c]  <= '0;
                r_prev[c] <= '0;
            end
            r_count    <= '0;
            r_first    <= 1'b1;
            r_last_cap <= '0;
        end else begin
            if (accept && r_rec_en) begin
                for (int c = 0; c < MAX_CH; c++) begin
                    if (c < CHANNELS) begin
                        r_sum[c] <= r_sum[c] + SUM_W'(in_ch[c]);
                    end
                end
                r_count <= r_count + 1'b1;
            end
            if (r_state == S_DIV_WAIT && div_rsp.done) begin
                r_prev[r_ch] <= div_rsp.quot;
                r_sum[r_ch]  <= '0;
                if (ch_done) begin
                    r_count <= '0;
                end
            end
            if (load_out) begin
                if (capture) begin
                    r_last_cap <= r_now;
                end
                r_first <= 1'b0;
            end
        end
    end

    // Working registers of the current frame end.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_now <= i_in_data.now_time;
        end
        if (r_state == S_CHECK) begin
            r_ch      <= '0;
            r_changed <= 1'b0;
            for (int c = 0; c < MAX_CH; c++) begin
                r_avg[c] <= '0;
            end
        end else if (r_state == S_DIV_WAIT && div_rsp.done) begin
            r_avg[r_ch] <= div_rsp.quot;
            if (diff > r_thresh) begin
                r_changed <= 1'b1;
            end
            if (!ch_done) begin
                r_ch <= r_ch + 1'b1;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out.capture        <= capture;
            r_out.colour_changed <= r_changed;
            r_out.avg0           <= r_avg[0];
            r_out.avg1           <= r_avg[1];
            r_out.avg2           <= r_avg[2];
            r_out.avg3           <= r_avg[3];
            r_out.frame_time     <= r_now;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### src/fcct_div.sv
// Shared saturating divider: one compare and subtract per cycle, giving an
// 8-bit quotient clamped at its maximum. Depends on fcct_pkg.
module fcct_div
    import fcct_pkg::*;
#(
    parameter int CNT_W = 26
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_div_req                i_req,
    input  logic [CNT_W+QUOT_W-1:0] i_dividend,
    input  logic [CNT_W-1:0]        i_divisor,
    output t_div_rsp                o_rsp
);

    localparam int SUM_W  = CNT_W + QUOT_W;
    localparam int STEP_W = $clog2(QUOT_W + 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUOT_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [SUM_W-1:0]  r_rem;
    logic [SUM_W-1:0]  r_den;
    logic [QUOT_W-1:0] r_quot;
    logic              ge;

    // The single shared compare.
    assign ge = (r_rem >= r_den);

    // Step zero tests for overflow of the quotient; steps one to eight each
    // produce one quotient bit, most significant first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_rem  <= i_dividend;
                r_den  <= {i_divisor, {QUOT_W{1'b0}}};
                r_quot <= '0;
            end else if (r_busy) begin
                if (r_step == '0) begin
                    if (ge) begin
                        r_quot <= '1;
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_den  <= r_den >> 1;
                        r_step <= r_step + 1'b1;
                    end
                end else begin
                    if (ge) begin
                        r_rem <= r_rem - r_den;
                    end
                    r_quot <= {r_quot[QUOT_W-2:0], ge};
                    r_den  <= r_den >> 1;
                    if (r_step == LAST_STEP) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

### tb/tb_frame_change_capture_trigger.sv
// Self-checking testbench for frame_change_capture_trigger: per-frame averages,
// colour-change and capture decisions checked against an in-bench predictor.
// Depends on fcct_pkg and the frame_change_capture_trigger RTL.
module tb_frame_change_capture_trigger;
    import fcct_pkg::*;

    localparam int QUIET_CYCLES   = 60;    // longer than a frame end's processing
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 4000;  // cycles without any traffic
    localparam int RANDOM_TARGET  = 1400;

    // Expected frame results and a private copy of the block's state.
    class frame_scoreboard;
        bit                rec_en;
        bit [12:0]         width_reg;
        bit [12:0]         height_reg;
        bit [7:0]          thresh;
        bit [31:0]         limit;
        longint unsigned   sums [4];
        longint unsigned   count;
        bit [7:0]          prev_avg [4];
        bit                first_pending;
        bit [63:0]         last_cap;
        t_out_item         expected_frames [$];
        int                errors;
        int                frames;
        int                captures;
        int                changes;
        int                pixels_seen;
        int                pixels_ignored;

        function new();
            rec_en        = 1'b1;
            width_reg     = 13'd1280;
            height_reg    = 13'd720;
            thresh        = 8'd16;
            limit         = 32'd1000000;
            count         = 0;
            first_pending = 1'b1;
            last_cap      = '0;
            for (int c = 0; c < 4; c++) begin
                sums[c]     = 0;
                prev_avg[c] = '0;
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_RECORD_ENABLE:    rec_en     = val[0];
                CFG_FRAME_WIDTH:      width_reg  = val[12:0];
                CFG_FRAME_HEIGHT:     height_reg = val[12:0];
                CFG_CHANGE_THRESHOLD: thresh     = val[7:0];
                CFG_TIME_LIMIT:       limit      = val[31:0];
                default: ;
            endcase
        endfunction

        // Zero counts as one and anything above the maximum as the maximum.
        function longint unsigned clamp_dim(bit [12:0] v);
            if (v == 0) return 1;
            if (v > 13'd4096) return 4096;
            return v;
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction

        // Accumulate one accepted pixel; queue a result when it closes a frame.
        function void absorb_pixel(t_in_item px);
            bit [7:0]        chan [4];
            bit [7:0]        avg [4];
            longint unsigned frame_pixels;
            longint unsigned quot;
            bit [7:0]        diff;
            bit [63:0]       elapsed;
            bit              changed;
            t_out_item       res;
            pixels_seen++;
            if (!rec_en) begin
                pixels_ignored++;
                return;
            end
            chan[0] = px.chan0;
            chan[1] = px.chan1;
            chan[2] = px.chan2;
            chan[3] = px.chan3;
            for (int c = 0; c < 4; c++) sums[c] += chan[c];
            count++;
            frame_pixels = clamp_dim(width_reg) * clamp_dim(height_reg);
            if (count < frame_pixels) return;

            // Frame end: truncated, saturating averages and the change test.
            changed = 1'b0;
            for (int c = 0; c < 4; c++) begin
                quot   = sums[c] / frame_pixels;
                avg[c] = (quot > 255) ? 8'hFF : quot[7:0];
                diff   = (avg[c] > prev_avg[c]) ? avg[c] - prev_avg[c]
                                                : prev_avg[c] - avg[c];
                if (diff > thresh) changed = 1'b1;
                prev_avg[c] = avg[c];
                sums[c]     = 0;
            end
            count   = 0;
            elapsed = px.now_time - last_cap;

            res.colour_changed = changed;
            res.capture        = changed || first_pending || (elapsed > {32'd0, limit});
            res.avg0           = avg[0];
            res.avg1           = avg[1];
            res.avg2           = avg[2];
            res.avg3           = avg[3];
            res.frame_time     = px.now_time;
            if (res.capture) last_cap = px.now_time;
            first_pending = 1'b0;
            expected_frames = {expected_frames, res};
        endfunction

        function void cmp_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        // Compare one accepted result with the oldest expectation.
        function void check_frame(t_out_item got);
            t_out_item want;
            if (expected_frames.size() == 0) begin
                $error("frame result with none outstanding, frame_time %0h", got.frame_time);
                errors++;
                return;
            end
            want = expected_frames.pop_front();
            frames++;
            if (want.capture) captures++;
            if (want.colour_changed) changes++;
            cmp_field("capture", want.capture, got.capture);
            cmp_field("colour_changed", want.colour_changed, got.colour_changed);
            cmp_field("avg0", want.avg0, got.avg0);
            cmp_field("avg1", want.avg1, got.avg1);
            cmp_field("avg2", want.avg2, got.avg2);
            cmp_field("avg3", want.avg3, got.avg3);
            cmp_field("frame_time", want.frame_time, got.frame_time);
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_RECORD_ENABLE;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  pix_valid = 1'b0;
    logic                  pix_ready;
    t_in_item              pix_data  = '0;
    logic                  res_valid;
    logic                  res_ready = 1'b0;
    t_out_item             res_data;

    frame_scoreboard sb = new();

    bit        send_idle  = 1'b0;
    bit        recv_idle  = 1'b0;
    int        hold_token = 0;
    int        hold_seen  = 0;
    int        stall_left = 0;
    int        quiet      = 0;
    bit [63:0] clock_now  = '0;
    bit [7:0]  base_colour [4];
    bit [7:0]  noise_mask = 8'hFF;

    frame_change_capture_trigger uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (pix_valid),
        .o_in_ready  (pix_ready),
        .i_in_data   (pix_data),
        .o_out_valid (res_valid),
        .i_out_ready (res_ready),
        .o_out_data  (res_data)
    );

    always #1 clk = ~clk;

    // Receiver: random stall bursts, plus a long hold-off on request.
    always @(posedge clk) begin
        if (!rst_n) begin
            res_ready <= 1'b0;
        end else if (stall_left > 0) begin
            res_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (hold_token != hold_seen) begin
            hold_seen  = hold_token;
            stall_left = HOLD_CYCLES - 1;
            res_ready <= 1'b0;
        end else if (recv_idle && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 8);
            res_ready <= 1'b0;
        end else begin
            res_ready <= 1'b1;
        end
    end

    // Monitor both channels and watch for a stuck block.
    always @(posedge clk) begin
        if (rst_n) begin
            if (pix_valid && pix_ready) sb.absorb_pixel(pix_data);
            if (res_valid && res_ready) sb.check_frame(res_data);
            if ((pix_valid && pix_ready) || (res_valid && res_ready) || cfg_we) begin
                quiet = 0;
            end else begin
                quiet = quiet + 1;
            end
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no traffic for %0d cycles", WATCHDOG_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic t_in_item mk_px(bit [7:0] c0, bit [7:0] c1, bit [7:0] c2,
                                       bit [7:0] c3, bit [63:0] t);
        t_in_item px;
        px.chan0    = c0;
        px.chan1    = c1;
        px.chan2    = c2;
        px.chan3    = c3;
        px.now_time = t;
        return px;
    endfunction

    // Pixel around a slowly changing base colour; time mostly runs forwards.
    function automatic t_in_item random_pixel();
        bit [7:0] c [4];
        if ($urandom_range(0, 7) == 0) begin
            for (int i = 0; i < 4; i++) base_colour[i] = 8'($urandom_range(0, 255));
        end
        for (int i = 0; i < 4; i++) c[i] = base_colour[i] ^ (noise_mask & 8'($urandom));
        if ($urandom_range(0, 63) == 0) clock_now = {$urandom, $urandom};
        else clock_now = clock_now + $urandom_range(0, 20);
        return mk_px(c[0], c[1], c[2], c[3], clock_now);
    endfunction

    function automatic bit [12:0] pick_dim();
        case ($urandom_range(0, 9))
            0:       return 13'd0;
            1:       return 13'($urandom_range(5, 12));
            default: return 13'($urandom_range(1, 4));
        endcase
    endfunction

    // Offer one pixel request and hold it until accepted.
    task automatic push_pixel(t_in_item px);
        int gap;
        if (send_idle && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 9);
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= px;
        do @(posedge clk); while (!pix_ready);
    endtask

    // Stop offering, drain the outstanding results and let the block go idle.
    // It first waits on the clock so that the monitor has noted the last accepted request.
    task automatic settle();
        pix_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic push_random(int n);
        for (int i = 0; i < n; i++) push_pixel(random_pixel());
    endtask

    initial begin
        bit [63:0] t_mid;
        int        random_items;
        int        n;
        t_mid        = 64'h8000_0000_0000_0000;
        random_items = 0;
        for (int i = 0; i < 4; i++) base_colour[i] = 8'($urandom_range(0, 255));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: one-pixel frames, zero threshold, widest time limit.
        write_reg(CFG_RECORD_ENABLE, 32'd1);
        write_reg(CFG_FRAME_WIDTH, 32'd1);
        write_reg(CFG_FRAME_HEIGHT, 32'd1);
        write_reg(CFG_CHANGE_THRESHOLD, 32'd0);
        write_reg(CFG_TIME_LIMIT, 32'hFFFF_FFFF);
        push_pixel(mk_px(8'h00, 8'h00, 8'h00, 8'h00, 64'd0));   // first frame
        push_pixel(mk_px(8'hFF, 8'hFF, 8'hFF, 8'hFF, 64'd10));  // full swing
        push_pixel(mk_px(8'hFF, 8'hFF, 8'hFF, 8'hFF, 64'd11));  // no change
        push_pixel(mk_px(8'hAA, 8'h55, 8'h0F, 8'hF0, 64'd12));
        push_pixel(mk_px(8'hAA, 8'h55, 8'h0F, 8'hF0, '1));      // time limit exceeded
        push_pixel(mk_px(8'hAA, 8'h55, 8'h0F, 8'hF0, 64'd4));   // time wraps round
        push_pixel(mk_px(8'h01, 8'h00, 8'h00, 8'h00, t_mid));

        // Threshold boundary with a zero time limit.
        settle();
        write_reg(CFG_CHANGE_THRESHOLD, 32'd16);
        write_reg(CFG_TIME_LIMIT, 32'd0);
        push_pixel(mk_px(8'd100, 8'd100, 8'd100, 8'd100, t_mid));
        push_pixel(mk_px(8'd116, 8'd84, 8'd100, 8'd100, t_mid));
        push_pixel(mk_px(8'd133, 8'd100, 8'd100, 8'd100, t_mid + 1));

        // Largest threshold: nothing can count as changed.
        settle();
        write_reg(CFG_CHANGE_THRESHOLD, 32'd255);
        write_reg(CFG_TIME_LIMIT, 32'hFFFF_FFFF);
        push_pixel(mk_px(8'h00, 8'hFF, 8'h00, 8'hFF, t_mid + 1));

        // Zero dimensions behave as one.
        settle();
        write_reg(CFG_FRAME_WIDTH, 32'd0);
        write_reg(CFG_FRAME_HEIGHT, 32'd0);
        push_pixel(mk_px(8'd7, 8'd7, 8'd7, 8'd7, t_mid + 2));

        // Two-pixel frame: truncating division.
        settle();
        write_reg(CFG_FRAME_WIDTH, 32'd2);
        write_reg(CFG_FRAME_HEIGHT, 32'd1);
        write_reg(CFG_CHANGE_THRESHOLD, 32'd16);
        push_pixel(mk_px(8'd1, 8'd3, 8'd255, 8'd0, t_mid + 3));
        push_pixel(mk_px(8'd2, 8'd4, 8'd254, 8'd1, t_mid + 4));

        // Frame shrunk part way through: the average saturates.
        settle();
        write_reg(CFG_FRAME_WIDTH, 32'd8);
        for (int i = 0; i < 5; i++) push_pixel(mk_px(8'hFF, 8'hFF, 8'hFF, 8'h10, t_mid + 5));
        settle();
        write_reg(CFG_FRAME_WIDTH, 32'd1);
        push_pixel(mk_px(8'hFF, 8'hFF, 8'hFF, 8'h10, t_mid + 6));

        // Recording switched off in the middle of a frame keeps the partial sums.
        settle();
        write_reg(CFG_FRAME_WIDTH, 32'd3);
        push_pixel(mk_px(8'd20, 8'd20, 8'd20, 8'd20, t_mid + 7));
        settle();
        write_reg(CFG_RECORD_ENABLE, 32'd0);
        for (int i = 0; i < 3; i++) push_pixel(mk_px(8'hFF, 8'hFF, 8'hFF, 8'hFF, t_mid + 8));
        settle();
        write_reg(CFG_RECORD_ENABLE, 32'd1);
        push_pixel(mk_px(8'd20, 8'd20, 8'd20, 8'd20, t_mid + 9));
        push_pixel(mk_px(8'd20, 8'd20, 8'd20, 8'd20, t_mid + 10));

        // Widest line, clamped from the top of the register, with zero height,
        // cut short by shrinking it.
        settle();
        clock_now = t_mid + 11;
        send_idle = 1'b1;
        recv_idle = 1'b1;
        write_reg(CFG_FRAME_WIDTH, 32'h1FFF);
        write_reg(CFG_FRAME_HEIGHT, 32'd0);
        push_random(300);
        settle();
        write_reg(CFG_FRAME_WIDTH, 32'd1);
        push_random(1);

        // Tallest frame, cut short by shrinking it.
        settle();
        write_reg(CFG_FRAME_WIDTH, 32'd1);
        write_reg(CFG_FRAME_HEIGHT, 32'd4096);
        push_random(6);
        settle();
        write_reg(CFG_FRAME_HEIGHT, 32'd1);
        push_random(1);

        // Back-pressure: results held off while one-pixel frames keep coming.
        settle();
        send_idle  = 1'b0;
        recv_idle  = 1'b0;
        hold_token = hold_token + 1;
        push_random(60);
        random_items += 60;

        // Random phases, each with its own settings.
        while (random_items < RANDOM_TARGET) begin
            settle();
            write_reg(CFG_FRAME_WIDTH, {19'd0, pick_dim()});
            write_reg(CFG_FRAME_HEIGHT, {19'd0, pick_dim()});
            if ($urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 5))
                    0:       write_reg(CFG_CHANGE_THRESHOLD, 32'd0);
                    1:       write_reg(CFG_CHANGE_THRESHOLD, 32'd255);
                    default: write_reg(CFG_CHANGE_THRESHOLD, $urandom_range(0, 40));
                endcase
            end
            if ($urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 4))
                    0:       write_reg(CFG_TIME_LIMIT, 32'd0);
                    1:       write_reg(CFG_TIME_LIMIT, 32'hFFFF_FFFF);
                    2:       write_reg(CFG_TIME_LIMIT, $urandom);
                    default: write_reg(CFG_TIME_LIMIT, $urandom_range(0, 60));
                endcase
            end
            case ($urandom_range(0, 3))
                0:       noise_mask = 8'h00;
                1:       noise_mask = 8'h03;
                2:       noise_mask = 8'h1F;
                default: noise_mask = 8'hFF;
            endcase
            // The last stretch of the run goes at full rate on both sides.
            if (random_items > RANDOM_TARGET - 300) begin
                send_idle = 1'b0;
                recv_idle = 1'b0;
            end else begin
                send_idle = ($urandom_range(0, 3) != 0);
                recv_idle = ($urandom_range(0, 3) != 0);
            end
            n = $urandom_range(40, 150);
            push_random(n);
            random_items += n;

            // Occasionally pause recording for a few requests.
            if ($urandom_range(0, 9) == 0) begin
                settle();
                write_reg(CFG_RECORD_ENABLE, 32'd0);
                push_random($urandom_range(2, 10));
                settle();
                write_reg(CFG_RECORD_ENABLE, 32'd1);
            end
        end

        // Drain, then watch a little longer for stray results.
        settle();
        if (sb.pending() != 0) begin
            $error("%0d frame results never arrived", sb.pending());
            sb.errors += sb.pending();
        end
        $display("Checked %0d frame results (%0d captures, %0d colour changes) from %0d pixels.",
                 sb.frames, sb.captures, sb.changes, sb.pixels_seen);
        $display("%0d pixels were sent with recording off; frame sizes ran from 1 to 4096.",
                 sb.pixels_ignored);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
